// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the core.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define EMO_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define EMO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define EMO_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/emo_pkg.sv
// Shared widths, saturation limits and register indices of the e^x-1 core.
// No dependencies.
`timescale 1ns / 1ps

package emo_pkg;

  // Port field widths
  localparam int ARG_W   = 45;
  localparam int SUM_W   = 64;
  localparam int TOL_W   = 63;
  localparam int MAXT_W  = 8;
  localparam int CFG_W   = 63;
  localparam int CFGI_W  = 1;

  // Internal datapath widths
  localparam int MAG_W   = 45;
  localparam int HALF_W  = 32;
  localparam int PROD_W  = 128;

  // Configuration register indices
  localparam logic [CFGI_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_MAX_TERMS = 1'b1;

  // Reset values of the registers
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1099512);
  localparam logic [MAXT_W-1:0] MAXT_RESET = MAXT_W'(255);

  // Saturation limits of a 64-bit signed word
  localparam logic [SUM_W-1:0] SAT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SAT_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

// File: rtl/core/emo_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on nothing; used by the e^x-1 top level.
`timescale 1ns / 1ps

module emo_div #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift the next dividend bit into the partial remainder and compare
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

// File: rtl/core/exp_minus_one_taylor_series.sv
// Top level of the e^x-1 Taylor series core: sequencer, multiplier and sum.
// Depends on emo_pkg and emo_div.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   config   | cfg_we, cfg_index, cfg_data               | in
//   argument | in_valid, in_ready, arg_x                 | in
//   result   | out_valid, out_ready, series_sum,         | out
//            | terms_used, limit_hit                     |
//
// Each term passes the bit-serial divider (one quotient bit per cycle over
// the 45-bit magnitude), the 32x32 partial-product multiplier and the
// negate, saturate and accumulate steps. in_ready is high only while the
// sequencer is idle. A finished result waits in the output register while
// the next argument is taken; the sequencer returns to idle, but no new
// argument is taken while a finished word still waits to enter that register.
// Reset is synchronous and restores control, configuration and out_valid.
`timescale 1ns / 1ps

module exp_minus_one_taylor_series
  import emo_pkg::*;
#(
  parameter int MAX_TERM_LIMIT = 255,
  parameter int FRAC_BITS      = 40
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFGI_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ARG_W-1:0]  arg_x,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SUM_W-1:0]  series_sum,
  output logic [MAXT_W-1:0]        terms_used,
  output logic                     limit_hit
);

  localparam int NW    = $clog2(MAX_TERM_LIMIT + 2);
  localparam int CMP_W = (NW > MAXT_W) ? NW : MAXT_W;
  localparam int TOP_W = PROD_W - FRAC_BITS - SUM_W + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL  = 6'b000100,
    S_NEG  = 6'b001000,
    S_TERM = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

  state_t state;
  logic   in_fire;
  logic   done_pending;

  // Configuration registers
  logic [TOL_W-1:0]  tolerance;
  logic [MAXT_W-1:0] max_terms;

  // Item registers
  logic [MAG_W-1:0]  xm;
  logic              xneg;
  logic [SUM_W-1:0]  term;
  logic [SUM_W-1:0]  sum;
  logic [NW-1:0]     n;

  // Divider hookup
  logic              div_start;
  logic              div_done;
  logic [MAG_W-1:0]  div_quo;
  logic [NW-1:0]     div_den;

  // Multiplier registers
  logic [SUM_W-1:0]  ua;
  logic [MAG_W-1:0]  ub;
  logic              neg;
  logic [2:0]        mul_cnt;
  logic [1:0]        pp_lane;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;

  // Combinational helpers
  logic [MAG_W-1:0]  in_mag;
  logic [HALF_W-1:0] a_sel;
  logic [HALF_W-1:0] b_sel;
  logic [PROD_W-1:0] pp_ext;
  logic signed [TOP_W-1:0] prod_top;
  logic              term_ovf;
  logic [SUM_W-1:0]  term_new;
  logic [SUM_W-1:0]  sum_raw;
  logic [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]  term_mag;
  logic [CMP_W-1:0]  n_ext;
  logic [CMP_W-1:0]  maxt_ext;
  logic              stop;

  assign in_ready = (state == S_IDLE) && !done_pending;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      max_terms <= MAXT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tolerance <= cfg_data;
        CFG_MAX_TERMS: max_terms <= cfg_data[MAXT_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude of the incoming argument
  assign in_mag = arg_x[ARG_W-1] ? (MAG_W'(~arg_x) + MAG_W'(1)) : MAG_W'(arg_x);

  // Quotient |x|/(n+1) comes from the shared serial divider
  assign div_den = n + NW'(1);

  emo_div #(
    .NUM_W (MAG_W),
    .DEN_W (NW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (xm),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Select the 32-bit halves for the current partial product
  assign a_sel = mul_cnt[1] ? ua[2*HALF_W-1:HALF_W] : ua[HALF_W-1:0];
  assign b_sel = mul_cnt[0] ? HALF_W'(ub[MAG_W-1:HALF_W]) : ub[HALF_W-1:0];

  // Align the registered partial product by its lane
  always_comb begin
    case (pp_lane)
      2'd0:    pp_ext = PROD_W'(pp);
      2'd3:    pp_ext = PROD_W'(pp) << (2 * HALF_W);
      default: pp_ext = PROD_W'(pp) << HALF_W;
    endcase
  end

  // Shift the product down and saturate to 64 bits
  assign prod_top = TOP_W'(prod >>> (FRAC_BITS + SUM_W - 1));
  assign term_ovf = (prod_top != '0) && (prod_top != '1);
  assign term_new = term_ovf ? (prod[PROD_W-1] ? SAT_MIN : SAT_MAX)
                             : prod[FRAC_BITS +: SUM_W];

  // Saturating running sum
  assign sum_raw = sum + term;
  assign sum_new = ((sum[SUM_W-1] == term[SUM_W-1]) &&
                    (sum_raw[SUM_W-1] != sum[SUM_W-1]))
                   ? (sum[SUM_W-1] ? SAT_MIN : SAT_MAX) : sum_raw;

  // Stop test on the new term and the index
  assign term_mag = term[SUM_W-1] ? (~term + SUM_W'(1)) : term;
  assign n_ext    = CMP_W'(n);
  assign maxt_ext = CMP_W'(max_terms);
  assign stop     = (term_mag < {1'b0, tolerance}) || (n_ext >= maxt_ext) ||
                    (n >= NW'(MAX_TERM_LIMIT));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_start    <= 1'b0;
      done_pending <= 1'b0;
      mul_cnt      <= '0;
    end else begin
      div_start <= 1'b0;
      if (done_pending && (!out_valid || out_ready)) begin
        done_pending <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mul_cnt <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          mul_cnt <= mul_cnt + 3'd1;
          if (mul_cnt == 3'd4) begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          state <= S_TERM;
        end
        S_TERM: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (stop) begin
            done_pending <= 1'b1;
            state        <= S_IDLE;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          xm   <= in_mag;
          xneg <= arg_x[ARG_W-1];
          term <= SUM_W'(arg_x);
          sum  <= SUM_W'(arg_x);
          n    <= NW'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          ua   <= term[SUM_W-1] ? (~term + SUM_W'(1)) : term;
          ub   <= div_quo;
          neg  <= term[SUM_W-1] ^ xneg;
          acc  <= '0;
        end
      end
      S_MUL: begin
        // Multiply one lane, add the previous lane's product
        if (mul_cnt != 3'd4) begin
          pp      <= a_sel * b_sel;
          pp_lane <= mul_cnt[1:0];
        end
        if (mul_cnt != 3'd0) begin
          acc <= acc + pp_ext;
        end
      end
      S_NEG: begin
        prod <= neg ? (~acc + PROD_W'(1)) : acc;
      end
      S_TERM: begin
        term <= term_new;
      end
      S_SUM: begin
        sum <= sum_new;
        if (!stop) begin
          n <= n + NW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register: load the finished word when free, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_pending && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_pending && (!out_valid || out_ready)) begin
      series_sum <= sum;
      terms_used <= n_ext[MAXT_W-1:0];
      limit_hit  <= (n_ext == maxt_ext);
    end
  end

endmodule

// File: rtl/core/emo_checker.sv
// Port-level checker for the e^x-1 core, bound to the top level below.
// Depends on emo_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emo_checker
  import emo_pkg::*;
#(
  parameter int MAX_TERM_LIMIT = 255
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] series_sum,
  input logic [MAXT_W-1:0]       terms_used,
  input logic                    limit_hit
);

  // Result word as one vector for the hold check
  logic [SUM_W+MAXT_W:0] out_word;

  assign out_word = {series_sum, terms_used, limit_hit};

  // After reset the core is empty and open for a word
  `EMO_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid && in_ready)

  // An accepted argument keeps the core busy in the next cycle
  `EMO_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A stalled result holds its word
  `EMO_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // At least one term is always formed
  `EMO_ASSERT_IMPL(a_terms_nonzero, clk, rst, (MAX_TERM_LIMIT < 256) && out_valid, terms_used != '0)

endmodule

bind exp_minus_one_taylor_series emo_checker #(
  .MAX_TERM_LIMIT (MAX_TERM_LIMIT)
) u_emo_checker (.*);

// File: tb/emo_series_checker.sv
`timescale 1ns / 1ps
// Result checker for the e^x-1 Taylor series core: watches the register, argument
// and result ports, predicts every result word and compares it. Depends on emo_pkg.

module emo_series_checker
  import emo_pkg::*;
#(
  parameter int MAX_TERM_LIMIT = 255,
  parameter int FRAC_BITS      = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFGI_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [ARG_W-1:0] arg_x,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [SUM_W-1:0] series_sum,
  input  logic [MAXT_W-1:0]       terms_used,
  input  logic                    limit_hit,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [MAXT_W-1:0]       terms;
    logic                    hit;
  } series_t;

  series_t           series_q[$];
  logic [TOL_W-1:0]  tol_reg  = TOL_RESET;
  logic [MAXT_W-1:0] maxt_reg = MAXT_RESET;
  int                mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [SUM_W-1:0] magnitude(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? -v : v;
  endfunction

  // Sum the series for one argument under the given tolerance and term limit
  function automatic series_t taylor_series(input logic signed [ARG_W-1:0] x,
                                            input logic [TOL_W-1:0] tol,
                                            input logic [MAXT_W-1:0] maxt);
    logic [SUM_W-1:0]         term;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W-1:0]         quot;
    logic [SUM_W-1:0]         xmag;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    logic                     done;
    int                       n;
    series_t                  r;
    term = {{(SUM_W-ARG_W){x[ARG_W-1]}}, x};
    sum  = term;
    xmag = magnitude(term);
    n    = 0;
    done = 1'b0;
    while (!done) begin
      n++;
      // Divide the magnitude, then restore the sign of x
      quot = xmag / SUM_W'(n + 1);
      if (x[ARG_W-1])
        quot = -quot;
      // Full-width product, arithmetic shift, saturate to 64 bits
      prod    = $signed({{SUM_W{term[SUM_W-1]}}, term}) *
                $signed({{SUM_W{quot[SUM_W-1]}}, quot});
      shifted = prod >>> FRAC_BITS;
      if (shifted[PROD_W-1:SUM_W-1] != {(PROD_W-SUM_W+1){shifted[PROD_W-1]}})
        term = prod[PROD_W-1] ? SAT_MIN : SAT_MAX;
      else
        term = shifted[SUM_W-1:0];
      // Saturating accumulate
      sum_next = sum + term;
      if (sum[SUM_W-1] == term[SUM_W-1] && sum_next[SUM_W-1] != sum[SUM_W-1])
        sum_next = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
      sum  = sum_next;
      done = (magnitude(term) < {1'b0, tol}) || (n >= maxt) || (n >= MAX_TERM_LIMIT);
    end
    r.sum   = sum;
    r.terms = MAXT_W'(n);
    r.hit   = (n == maxt);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    series_t want;
    if (rst) begin
      tol_reg  <= TOL_RESET;
      maxt_reg <= MAXT_RESET;
      series_q.delete();
    end else begin
      // Track register writes; the user must write them only while the core is idle (not enforced)
      if (cfg_we) begin
        if (cfg_index == CFG_TOLERANCE)
          tol_reg <= cfg_data[TOL_W-1:0];
        else if (cfg_index == CFG_MAX_TERMS)
          maxt_reg <= cfg_data[MAXT_W-1:0];
      end
      // Retire the oldest prediction against each result word
      if (out_valid && out_ready) begin
        if (series_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing predicted, series_sum %0d terms_used %0d",
                   $time, series_sum, terms_used);
        end else begin
          want = series_q.pop_front();
          if (series_sum !== want.sum) begin
            mismatches++;
            $display("%0t: series_sum expected %0d, actual %0d",
                     $time, $signed(want.sum), series_sum);
          end
          if (terms_used !== want.terms) begin
            mismatches++;
            $display("%0t: terms_used expected %0d, actual %0d",
                     $time, want.terms, terms_used);
          end
          if (limit_hit !== want.hit) begin
            mismatches++;
            $display("%0t: limit_hit expected %0b, actual %0b",
                     $time, want.hit, limit_hit);
          end
        end
      end
      // Predict the result of each argument word taken
      if (in_valid && in_ready)
        series_q.push_back(taylor_series(arg_x, tol_reg, maxt_reg));
    end
    fail_count <= mismatches;
    pending    <= series_q.size();
  end

endmodule

// File: tb/exp_minus_one_taylor_series_tb.sv
`timescale 1ns / 1ps
// Bench top for the e^x-1 Taylor series core: clock, reset, argument source,
// result sink and verdict. Depends on emo_pkg, the core and emo_series_checker.

module exp_minus_one_taylor_series_tb;
  import emo_pkg::*;

  localparam int MAX_TERM_LIMIT = 255;
  localparam int FRAC_BITS      = 40;
  localparam int HOLD_LEN       = 3000;
  localparam int SETTLE         = 16;
  localparam int TAIL           = 300;
  // Worst case is 255 terms an item, plus stalls,
  // for some 650 items; take that several times over
  localparam longint LIMIT_CYCLES = 40_000_000;

  localparam logic signed [ARG_W-1:0] ARG_MAX = {1'b0, {(ARG_W-1){1'b1}}};
  localparam logic signed [ARG_W-1:0] ARG_MIN = {1'b1, {(ARG_W-1){1'b0}}};

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [CFGI_W-1:0]       cfg_index = CFG_TOLERANCE;
  logic [CFG_W-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [ARG_W-1:0] arg_x     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] series_sum;
  logic [MAXT_W-1:0]       terms_used;
  logic                    limit_hit;
  int                      fail_count;
  int                      pending;

  bit calm        = 1'b0;
  int hold_count  = 0;
  int holds_done  = 0;
  int stall_left  = 0;

  always #4 clk = ~clk;

  exp_minus_one_taylor_series #(
    .MAX_TERM_LIMIT (MAX_TERM_LIMIT),
    .FRAC_BITS      (FRAC_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .arg_x      (arg_x),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .series_sum (series_sum),
    .terms_used (terms_used),
    .limit_hit  (limit_hit)
  );

  emo_series_checker #(
    .MAX_TERM_LIMIT (MAX_TERM_LIMIT),
    .FRAC_BITS      (FRAC_BITS)
  ) series_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .arg_x      (arg_x),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .series_sum (series_sum),
    .terms_used (terms_used),
    .limit_hit  (limit_hit),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70)
      return 0;
    if (p < 90)
      return $urandom_range(1, 3);
    if (p < 98)
      return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic signed [ARG_W-1:0] to_q40(input int whole);
    return ARG_W'(whole) <<< FRAC_BITS;
  endfunction

  // Bias towards small arguments to keep the term counts down
  function automatic logic signed [ARG_W-1:0] pick_arg();
    logic signed [ARG_W-1:0] v;
    int p;
    v = ARG_W'({$urandom, $urandom});
    p = $urandom_range(0, 9);
    if (p < 6)
      v = v >>> 4;
    else if (p < 8)
      v = v >>> 1;
    else if (p == 8)
      v = v >>> $urandom_range(5, ARG_W - 1);
    return v;
  endfunction

  // Hold valid and the word until taken, then idle for a random gap
  task automatic send_arg(input logic signed [ARG_W-1:0] x);
    int gap;
    gap = calm ? 0 : idle_len();
    in_valid <= 1'b1;
    arg_x    <= x;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop the source and wait for every predicted word to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers back to back; call only when idle
  task automatic load_config(input logic [TOL_W-1:0] tol, input logic [MAXT_W-1:0] maxt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= tol;
    @(posedge clk);
    cfg_index <= CFG_MAX_TERMS;
    cfg_data  <= CFG_W'(maxt);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result sink: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holds_done != hold_count) begin
      holds_done <= hold_count;
      stall_left <= HOLD_LEN;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_len();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [TOL_W-1:0]  tol;
    logic [MAXT_W-1:0] maxt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero, smallest steps, unit, range ends, field ends
    send_arg('0);
    send_arg(ARG_W'(1));
    send_arg(-ARG_W'(1));
    send_arg(to_q40(1));
    send_arg(-to_q40(1));
    send_arg(to_q40(1) >>> 1);
    send_arg(to_q40(10));
    send_arg(to_q40(-10));
    send_arg(ARG_MAX);
    send_arg(ARG_MIN);
    drain();

    // Term limit of zero: a single term, flag low
    load_config(TOL_RESET, '0);
    send_arg(to_q40(1));
    send_arg(to_q40(-3));
    drain();

    // Zero tolerance: run to the term ceiling
    load_config('0, '1);
    send_arg(to_q40(1));
    send_arg(ARG_MAX);
    drain();

    // Widest tolerance with a limit of one term
    load_config('1, MAXT_W'(1));
    send_arg(to_q40(5));
    send_arg(to_q40(-5));
    drain();

    // Smallest nonzero tolerance
    load_config(TOL_W'(1), '1);
    send_arg(ARG_MAX);
    send_arg(to_q40(-7));
    drain();

    // Long sink hold with a steady source so the core fills and stalls
    load_config(TOL_RESET, MAXT_W'(3));
    calm = 1'b1;
    hold_count <= hold_count + 1;
    repeat (20) send_arg(pick_arg());
    drain();
    repeat (10) send_arg(pick_arg());
    drain();

    // Random phases, each under fresh settings
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph % 4 == 1);
      case ($urandom_range(0, 5))
        0:       tol = '0;
        1:       tol = TOL_RESET;
        2:       tol = TOL_W'($urandom_range(1, 1 << 20));
        3:       tol = TOL_W'({$urandom, $urandom} >> $urandom_range(23, 62));
        4:       tol = '1;
        default: tol = TOL_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 4))
        0:       maxt = '0;
        1:       maxt = MAXT_W'(1);
        2:       maxt = MAXT_W'($urandom_range(2, 12));
        3:       maxt = '1;
        default: maxt = MAXT_W'($urandom_range(0, 255));
      endcase
      // Keep tight tolerances cheap
      if (tol < 1024 && maxt > 24)
        maxt = MAXT_W'($urandom_range(2, 24));
      load_config(tol, maxt);
      repeat (48) send_arg(pick_arg());
      drain();
    end

    repeat (TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
